// ===== rtl/annular_sector_point_test_core_assert.svh =====
// ----------------------------------------------------------------------------
// annular sector point test - assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef ANNULAR_SECTOR_POINT_TEST_CORE_ASSERT_SVH
`define ANNULAR_SECTOR_POINT_TEST_CORE_ASSERT_SVH

// same-cycle implication
`define ASPTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASPTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/asptc_pkg.sv =====
// ----------------------------------------------------------------------------
// asptc_pkg
// shared types, register codes and constants of the annular sector test
// ----------------------------------------------------------------------------
package asptc_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int ATAN_LEN    = 24;
  localparam int TURN_W      = 32;
  localparam int RADIUS_W    = 32;
  localparam int ANGLE_REG_W = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  typedef logic [TURN_W-1:0] turn_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INNER_RADIUS_SQ = 2'd0,
    REG_OUTER_RADIUS_SQ = 2'd1,
    REG_ANGLE_START     = 2'd2,
    REG_ANGLE_END       = 2'd3
  } cfg_reg_t;

  localparam logic [RADIUS_W-1:0]    INNER_RADIUS_SQ_RST = 32'h0000_0000;
  localparam logic [RADIUS_W-1:0]    OUTER_RADIUS_SQ_RST = 32'h8000_0000;
  localparam logic [ANGLE_REG_W-1:0] ANGLE_START_RST     = 16'h0000;
  localparam logic [ANGLE_REG_W-1:0] ANGLE_END_RST       = 16'h8000;

  localparam turn_t ZERO_TURN          = 32'h0000_0000;
  localparam turn_t QUARTER_TURN       = 32'h4000_0000;
  localparam turn_t HALF_TURN          = 32'h8000_0000;
  localparam turn_t THREE_QUARTER_TURN = 32'hC000_0000;

  // atan(2^-i) in units of one turn / 2^32, truncated
  localparam turn_t ATAN_TURNS [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic valid;
    logic hold;
    logic pass;
  } stage_ctl_t;

endpackage

// ===== rtl/asptc_front.sv =====
// ----------------------------------------------------------------------------
// asptc_front
// two-stage front end: squares and vector setup, then radius window test
// ----------------------------------------------------------------------------
module asptc_front #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16,
  parameter int WORK_W        = 35
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic signed [COORD_WIDTH-1:0]        in_x,
  input  logic signed [COORD_WIDTH-1:0]        in_y,
  input  logic [asptc_pkg::RADIUS_W-1:0]       inner_radius_sq,
  input  logic [asptc_pkg::RADIUS_W-1:0]       outer_radius_sq,
  output asptc_pkg::stage_ctl_t                out_ctl,
  output logic signed [WORK_W-1:0]             out_x,
  output logic signed [WORK_W-1:0]             out_y,
  output asptc_pkg::turn_t                     out_z
);
  import asptc_pkg::*;

  localparam int SQ_W = 2 * COORD_WIDTH;
  localparam int RW   = (SQ_W > RADIUS_W) ? SQ_W : RADIUS_W;

  logic signed [COORD_WIDTH:0]   xe, ye, xa_full, ya_full;
  logic [COORD_WIDTH-1:0]        xa, ya;
  logic [SQ_W-1:0]               sqx, sqy;
  logic signed [WORK_W-1:0]      xw, yw, xn, yn;
  logic                          x_neg, x_zero, y_zero;
  turn_t                         z0;
  logic                          hold0;

  logic                          v1_r;
  logic [SQ_W-1:0]               sqx_r, sqy_r;
  logic signed [WORK_W-1:0]      x1_r, y1_r;
  turn_t                         z1_r;
  logic                          hold1_r;

  logic [RW-1:0]                 r2;
  logic                          pass;

  stage_ctl_t                    ctl2_r;
  logic signed [WORK_W-1:0]      x2_r, y2_r;
  turn_t                         z2_r;

  assign x_neg  = in_x[COORD_WIDTH-1];
  assign x_zero = (in_x == '0);
  assign y_zero = (in_y == '0);

  assign xe      = {in_x[COORD_WIDTH-1], in_x};
  assign ye      = {in_y[COORD_WIDTH-1], in_y};
  assign xa_full = xe[COORD_WIDTH] ? -xe : xe;
  assign ya_full = ye[COORD_WIDTH] ? -ye : ye;
  assign xa      = xa_full[COORD_WIDTH-1:0];
  assign ya      = ya_full[COORD_WIDTH-1:0];
  assign sqx     = {{COORD_WIDTH{1'b0}}, xa} * {{COORD_WIDTH{1'b0}}, xa};
  assign sqy     = {{COORD_WIDTH{1'b0}}, ya} * {{COORD_WIDTH{1'b0}}, ya};

  assign xw = WORK_W'(in_x);
  assign yw = WORK_W'(in_y);
  assign xn = x_neg ? -xw : xw;
  assign yn = x_neg ? -yw : yw;

  // axis points take a fixed angle and bypass the rotations
  always_comb begin
    priority if (y_zero) begin
      z0    = x_neg ? HALF_TURN : ZERO_TURN;
      hold0 = 1'b1;
    end else if (x_zero) begin
      z0    = in_y[COORD_WIDTH-1] ? THREE_QUARTER_TURN : QUARTER_TURN;
      hold0 = 1'b1;
    end else begin
      z0    = x_neg ? HALF_TURN : ZERO_TURN;
      hold0 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r   <= sqx;
      sqy_r   <= sqy;
      x1_r    <= xn <<< CORDIC_STAGES;
      y1_r    <= yn <<< CORDIC_STAGES;
      z1_r    <= z0;
      hold1_r <= hold0;
    end
  end

  assign r2   = RW'(sqx_r) + RW'(sqy_r);
  assign pass = !(r2 < RW'(inner_radius_sq)) && !(r2 > RW'(outer_radius_sq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (adv) begin
      ctl2_r <= '{valid: v1_r, hold: hold1_r, pass: pass};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x2_r <= x1_r;
      y2_r <= y1_r;
      z2_r <= z1_r;
    end
  end

  assign out_ctl = ctl2_r;
  assign out_x   = x2_r;
  assign out_y   = y2_r;
  assign out_z   = z2_r;

endmodule

// ===== rtl/asptc_cell.sv =====
// ----------------------------------------------------------------------------
// asptc_cell
// one vectoring rotation step, registered, handed to the next cell
// ----------------------------------------------------------------------------
module asptc_cell #(
  parameter int WORK_W = 35,
  parameter int STAGE  = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  asptc_pkg::stage_ctl_t     in_ctl,
  input  logic signed [WORK_W-1:0]  in_x,
  input  logic signed [WORK_W-1:0]  in_y,
  input  asptc_pkg::turn_t          in_z,
  output asptc_pkg::stage_ctl_t     out_ctl,
  output logic signed [WORK_W-1:0]  out_x,
  output logic signed [WORK_W-1:0]  out_y,
  output asptc_pkg::turn_t          out_z
);
  import asptc_pkg::*;

  logic signed [WORK_W-1:0] xs, ys, x_nxt, y_nxt;
  turn_t                    z_nxt;
  stage_ctl_t               ctl_r;
  logic signed [WORK_W-1:0] x_r, y_r;
  turn_t                    z_r;

  assign xs = in_x >>> STAGE;
  assign ys = in_y >>> STAGE;

  always_comb begin
    if (in_ctl.hold) begin
      x_nxt = in_x;
      y_nxt = in_y;
      z_nxt = in_z;
    end else if (!in_y[WORK_W-1]) begin
      x_nxt = in_x + ys;
      y_nxt = in_y - xs;
      z_nxt = in_z + ATAN_TURNS[STAGE];
    end else begin
      x_nxt = in_x - ys;
      y_nxt = in_y + xs;
      z_nxt = in_z - ATAN_TURNS[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign out_ctl = ctl_r;
  assign out_x   = x_r;
  assign out_y   = y_r;
  assign out_z   = z_r;

endmodule

// ===== rtl/asptc_sector.sv =====
// ----------------------------------------------------------------------------
// asptc_sector
// angle rounding, sector window compare and output word register
// ----------------------------------------------------------------------------
module asptc_sector #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  asptc_pkg::stage_ctl_t              in_ctl,
  input  asptc_pkg::turn_t                   in_z,
  input  logic [asptc_pkg::ANGLE_REG_W-1:0]  angle_start,
  input  logic [asptc_pkg::ANGLE_REG_W-1:0]  angle_end,
  output logic                               out_valid,
  output logic                               out_inside
);
  import asptc_pkg::*;

  localparam turn_t ROUND = TURN_W'(1) << (TURN_W - 1 - ANGLE_WIDTH);

  turn_t                               zr;
  logic [ANGLE_WIDTH-1:0]              ang, a0, a1;
  logic [ANGLE_WIDTH+ANGLE_REG_W-1:0]  a0_ext, a1_ext;
  logic                                hit;
  logic                                valid_r, inside_r;

  assign zr     = in_z + ROUND;
  assign ang    = zr[TURN_W-1 -: ANGLE_WIDTH];
  assign a0_ext = {{ANGLE_WIDTH{1'b0}}, angle_start};
  assign a1_ext = {{ANGLE_WIDTH{1'b0}}, angle_end};
  assign a0     = a0_ext[ANGLE_WIDTH-1:0];
  assign a1     = a1_ext[ANGLE_WIDTH-1:0];

  always_comb begin
    priority if (!in_ctl.pass) begin
      hit = 1'b0;
    end else if (a0 < a1) begin
      hit = (a0 < ang) && (ang < a1);
    end else if (a0 > a1) begin
      hit = (a0 < ang) || (ang < a1);
    end else begin
      hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inside_r <= hit;
    end
  end

  assign out_valid  = valid_r;
  assign out_inside = inside_r;

endmodule

// ===== rtl/annular_sector_point_test_core.sv =====
// ----------------------------------------------------------------------------
// annular_sector_point_test_core
// streaming test of a point against an annular sector window
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  in        in_valid, in_ready, in_point_x/y        word in
//  out       out_valid, out_ready, out_inside_res    word out
//  cfg       cfg_we, cfg_index, cfg_data             register write
//
//  one word per cycle while the output word is not stalled; register stages in order
//  (front squares stage, radius stage, one cell per rotation, sector stage)
//  rst_n synchronous, clears valid bits and loads register defaults
//  a stalled output word freezes the whole chain, in_ready follows it
// ----------------------------------------------------------------------------
module annular_sector_point_test_core #(
  parameter int COORD_WIDTH   = asptc_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = asptc_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = asptc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       in_point_x,
  input  logic signed [COORD_WIDTH-1:0]       in_point_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_inside_res,
  input  logic                                cfg_we,
  input  logic [asptc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [asptc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import asptc_pkg::*;

`include "annular_sector_point_test_core_assert.svh"

  localparam int WORK_W = COORD_WIDTH + CORDIC_STAGES + 3;

  logic [RADIUS_W-1:0]    inner_radius_sq_r, outer_radius_sq_r;
  logic [ANGLE_REG_W-1:0] angle_start_r, angle_end_r;
  logic                   adv;

  stage_ctl_t               c_ctl [CORDIC_STAGES+1];
  logic signed [WORK_W-1:0] c_x   [CORDIC_STAGES+1];
  logic signed [WORK_W-1:0] c_y   [CORDIC_STAGES+1];
  turn_t                    c_z   [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_radius_sq_r <= INNER_RADIUS_SQ_RST;
      outer_radius_sq_r <= OUTER_RADIUS_SQ_RST;
      angle_start_r     <= ANGLE_START_RST;
      angle_end_r       <= ANGLE_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INNER_RADIUS_SQ: inner_radius_sq_r <= cfg_data[RADIUS_W-1:0];
        REG_OUTER_RADIUS_SQ: outer_radius_sq_r <= cfg_data[RADIUS_W-1:0];
        REG_ANGLE_START:     angle_start_r     <= cfg_data[ANGLE_REG_W-1:0];
        REG_ANGLE_END:       angle_end_r       <= cfg_data[ANGLE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  asptc_front #(
    .COORD_WIDTH   (COORD_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES),
    .WORK_W        (WORK_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_valid),
    .in_x            (in_point_x),
    .in_y            (in_point_y),
    .inner_radius_sq (inner_radius_sq_r),
    .outer_radius_sq (outer_radius_sq_r),
    .out_ctl         (c_ctl[0]),
    .out_x           (c_x[0]),
    .out_y           (c_y[0]),
    .out_z           (c_z[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    asptc_cell #(
      .WORK_W (WORK_W),
      .STAGE  (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_ctl  (c_ctl[i]),
      .in_x    (c_x[i]),
      .in_y    (c_y[i]),
      .in_z    (c_z[i]),
      .out_ctl (c_ctl[i+1]),
      .out_x   (c_x[i+1]),
      .out_y   (c_y[i+1]),
      .out_z   (c_z[i+1])
    );
  end

  asptc_sector #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_sector (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_ctl      (c_ctl[CORDIC_STAGES]),
    .in_z        (c_z[CORDIC_STAGES]),
    .angle_start (angle_start_r),
    .angle_end   (angle_end_r),
    .out_valid   (out_valid),
    .out_inside  (out_inside_res)
  );

  `ASPTC_ASSERT_IMP(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready, !in_ready,
                    "input taken while output word stalled")

  `ASPTC_ASSERT_NXT(a_last_cell_delivers, clk, rst_n, adv && c_ctl[CORDIC_STAGES].valid,
                    out_valid, "word lost between last cell and output")

  `ASPTC_ASSERT_NXT(a_radius_fail_outside, clk, rst_n,
                    adv && c_ctl[CORDIC_STAGES].valid && !c_ctl[CORDIC_STAGES].pass,
                    !out_inside_res, "point outside radius window reported inside")

endmodule
